/* hdl/fifo_with_waiter_handoff_top_assert.svh */
// Assertion macros for the FIFO with waiter handoff.
// Depends on a clk and an active-low rst_n in the including module.
`ifndef FIFO_WITH_WAITER_HANDOFF_TOP_ASSERT_SVH
`define FIFO_WITH_WAITER_HANDOFF_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define FWH_ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FWH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FWH_ASSERT_NOW(label, prop, msg)
`define FWH_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* hdl/fwh_pkg.sv */
// Shared types and constants for the FIFO with waiter handoff.
// No dependencies.
`default_nettype none
package fwh_pkg;
    localparam int ITEM_DEPTH_DEF   = 16;
    localparam int WAITER_DEPTH_DEF = 8;
    localparam int DATA_WIDTH_DEF   = 32;
    localparam int VALUE_W          = 32;
    localparam int ID_W             = 8;
    localparam int COUNT_W          = 32;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DELIVERED = 3'd1,
        ST_PARKED    = 3'd2,
        ST_DROPPED   = 3'd3,
        ST_REJECTED  = 3'd4
    } status_t;

    // Decision taken at accept, finished in the following cycle with RAM read data
    typedef struct packed {
        status_t              status;
        logic                 use_item_ram;
        logic                 use_waiter_ram;
        logic [VALUE_W-1:0]   value;
        logic [ID_W-1:0]      who;
        logic [COUNT_W-1:0]   count;
    } pend_t;
endpackage
`default_nettype wire

/* hdl/fwh_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none
module fwh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

/* hdl/fwh_ctrl.sv */
// Pointer, level and handoff-count control for the FIFO with waiter handoff.
// Depends on fwh_pkg and the assertion header.
`default_nettype none
`include "fifo_with_waiter_handoff_top_assert.svh"
module fwh_ctrl #(
    parameter int ITEM_DEPTH   = fwh_pkg::ITEM_DEPTH_DEF,
    parameter int WAITER_DEPTH = fwh_pkg::WAITER_DEPTH_DEF,
    parameter int DATA_WIDTH   = fwh_pkg::DATA_WIDTH_DEF,
    localparam int IAW = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1,
    localparam int WAW = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1,
    localparam int ILW = $clog2(ITEM_DEPTH + 1),
    localparam int WLW = $clog2(WAITER_DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          operation,
    input  wire logic [fwh_pkg::VALUE_W-1:0]   item_value,
    input  wire logic [fwh_pkg::ID_W-1:0]      requester_id,
    output logic                               busy,
    output logic                               item_we,
    output logic      [IAW-1:0]                item_waddr,
    output logic      [DATA_WIDTH-1:0]         item_wdata,
    output logic                               item_re,
    output logic      [IAW-1:0]                item_raddr,
    output logic                               waiter_we,
    output logic      [WAW-1:0]                waiter_waddr,
    output logic      [fwh_pkg::ID_W-1:0]      waiter_wdata,
    output logic                               waiter_re,
    output logic      [WAW-1:0]                waiter_raddr,
    output logic                               pend_valid,
    output fwh_pkg::pend_t                     pend
);
    logic                           accept;
    logic [IAW-1:0]                 item_rd_ptr_reg, item_rd_ptr_next;
    logic [IAW-1:0]                 item_wr_ptr_reg, item_wr_ptr_next;
    logic [ILW-1:0]                 item_level_reg, item_level_next;
    logic [WAW-1:0]                 waiter_rd_ptr_reg, waiter_rd_ptr_next;
    logic [WAW-1:0]                 waiter_wr_ptr_reg, waiter_wr_ptr_next;
    logic [WLW-1:0]                 waiter_level_reg, waiter_level_next;
    logic [fwh_pkg::COUNT_W-1:0]    total_reg, total_next;
    logic                           pend_valid_reg, pend_valid_next;
    fwh_pkg::pend_t                 pend_reg, pend_next;

    assign accept = start && !pend_valid_reg;

    always_comb
    begin
        item_rd_ptr_next   = item_rd_ptr_reg;
        item_wr_ptr_next   = item_wr_ptr_reg;
        item_level_next    = item_level_reg;
        waiter_rd_ptr_next = waiter_rd_ptr_reg;
        waiter_wr_ptr_next = waiter_wr_ptr_reg;
        waiter_level_next  = waiter_level_reg;
        total_next         = total_reg;
        pend_valid_next    = 1'b0;
        pend_next          = pend_reg;
        item_we            = 1'b0;
        item_re            = 1'b0;
        waiter_we          = 1'b0;
        waiter_re          = 1'b0;
        if (accept)
        begin
            pend_valid_next          = 1'b1;
            pend_next.use_item_ram   = 1'b0;
            pend_next.use_waiter_ram = 1'b0;
            pend_next.value          = '0;
            pend_next.who            = '0;
            if (operation == fwh_pkg::OP_ENQUEUE)
            begin
                if (waiter_level_reg != '0)
                begin
                    // hand the word to the oldest waiter
                    waiter_re                = 1'b1;
                    waiter_rd_ptr_next       = (waiter_rd_ptr_reg == WAW'(WAITER_DEPTH - 1))
                                               ? '0 : waiter_rd_ptr_reg + 1'b1;
                    waiter_level_next        = waiter_level_reg - 1'b1;
                    total_next               = total_reg + 1'b1;
                    pend_next.use_waiter_ram = 1'b1;
                    pend_next.value          = fwh_pkg::VALUE_W'(item_wdata);
                    pend_next.status         = fwh_pkg::ST_DELIVERED;
                end
                else if (item_level_reg != ILW'(ITEM_DEPTH))
                begin
                    item_we          = 1'b1;
                    item_wr_ptr_next = (item_wr_ptr_reg == IAW'(ITEM_DEPTH - 1))
                                       ? '0 : item_wr_ptr_reg + 1'b1;
                    item_level_next  = item_level_reg + 1'b1;
                    pend_next.status = fwh_pkg::ST_STORED;
                end
                else
                begin
                    pend_next.status = fwh_pkg::ST_DROPPED;
                end
            end
            else
            begin
                if (item_level_reg != '0 && waiter_level_reg == '0)
                begin
                    // take the oldest stored word
                    item_re                = 1'b1;
                    item_rd_ptr_next       = (item_rd_ptr_reg == IAW'(ITEM_DEPTH - 1))
                                             ? '0 : item_rd_ptr_reg + 1'b1;
                    item_level_next        = item_level_reg - 1'b1;
                    total_next             = total_reg + 1'b1;
                    pend_next.use_item_ram = 1'b1;
                    pend_next.who          = requester_id;
                    pend_next.status       = fwh_pkg::ST_DELIVERED;
                end
                else if (waiter_level_reg != WLW'(WAITER_DEPTH))
                begin
                    waiter_we          = 1'b1;
                    waiter_wr_ptr_next = (waiter_wr_ptr_reg == WAW'(WAITER_DEPTH - 1))
                                         ? '0 : waiter_wr_ptr_reg + 1'b1;
                    waiter_level_next  = waiter_level_reg + 1'b1;
                    pend_next.status   = fwh_pkg::ST_PARKED;
                end
                else
                begin
                    pend_next.status = fwh_pkg::ST_REJECTED;
                end
            end
            pend_next.count = total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_rd_ptr_reg   <= '0;
            item_wr_ptr_reg   <= '0;
            item_level_reg    <= '0;
            waiter_rd_ptr_reg <= '0;
            waiter_wr_ptr_reg <= '0;
            waiter_level_reg  <= '0;
            total_reg         <= '0;
            pend_valid_reg    <= 1'b0;
        end
        else
        begin
            item_rd_ptr_reg   <= item_rd_ptr_next;
            item_wr_ptr_reg   <= item_wr_ptr_next;
            item_level_reg    <= item_level_next;
            waiter_rd_ptr_reg <= waiter_rd_ptr_next;
            waiter_wr_ptr_reg <= waiter_wr_ptr_next;
            waiter_level_reg  <= waiter_level_next;
            total_reg         <= total_next;
            pend_valid_reg    <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    assign busy         = pend_valid_reg;
    assign pend_valid   = pend_valid_reg;
    assign pend         = pend_reg;
    assign item_waddr   = item_wr_ptr_reg;
    assign item_raddr   = item_rd_ptr_reg;
    assign item_wdata   = DATA_WIDTH'(item_value);
    assign waiter_waddr = waiter_wr_ptr_reg;
    assign waiter_raddr = waiter_rd_ptr_reg;
    assign waiter_wdata = requester_id;

    `FWH_ASSERT_NOW(a_not_both_queued, !(item_level_reg != '0 && waiter_level_reg != '0), "items and waiters queued together")
    `FWH_ASSERT_NOW(a_item_level_bound, item_level_reg <= ILW'(ITEM_DEPTH), "item level overflow")
    `FWH_ASSERT_NOW(a_waiter_level_bound, waiter_level_reg <= WLW'(WAITER_DEPTH), "waiter level overflow")
    `FWH_ASSERT_NEXT(a_accept_pends, accept, pend_valid_reg, "accepted item not pending")
    `FWH_ASSERT_NOW(a_single_port_use, !(item_re && waiter_re) && !(item_we && waiter_we), "two stores touched by one item")
endmodule
`default_nettype wire

/* hdl/fifo_with_waiter_handoff_top.sv */
// Top level of the FIFO with waiter handoff: control, item RAM, waiter RAM, result register.
// Depends on fwh_pkg, fwh_ctrl, fwh_ram and the assertion header.
// An accepted item is held as pending in fwh_ctrl; its result is then merged into the result register and done rises.
// No new item is taken while one is pending; busy is high for the pending cycle, in which any registered
// read of the item or waiter RAM completes, and start is taken again while the result shows.
// Reset: rst_n clears pointers, levels, the delivery count and all strobes; the RAMs need no
// clearing pass, their levels guard every read. The receiver cannot stall the result.
`default_nettype none
`include "fifo_with_waiter_handoff_top_assert.svh"
module fifo_with_waiter_handoff_top #(
    parameter int ITEM_DEPTH   = fwh_pkg::ITEM_DEPTH_DEF,
    parameter int WAITER_DEPTH = fwh_pkg::WAITER_DEPTH_DEF,
    parameter int DATA_WIDTH   = fwh_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          operation,
    input  wire logic [fwh_pkg::VALUE_W-1:0]   item_value,
    input  wire logic [fwh_pkg::ID_W-1:0]      requester_id,
    output logic                               done,
    output logic      [2:0]                    status,
    output logic      [fwh_pkg::VALUE_W-1:0]   delivered_value,
    output logic      [fwh_pkg::ID_W-1:0]      consumer_id,
    output logic      [fwh_pkg::COUNT_W-1:0]   delivery_count
);
    localparam int IAW = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;
    localparam int WAW = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;

    logic                           item_we, item_re;
    logic [IAW-1:0]                 item_waddr, item_raddr;
    logic [DATA_WIDTH-1:0]          item_wdata, item_rdata;
    logic                           waiter_we, waiter_re;
    logic [WAW-1:0]                 waiter_waddr, waiter_raddr;
    logic [fwh_pkg::ID_W-1:0]       waiter_wdata, waiter_rdata;
    logic                           pend_valid;
    fwh_pkg::pend_t                 pend;

    logic                           done_reg;
    logic [2:0]                     status_reg;
    logic [fwh_pkg::VALUE_W-1:0]    value_reg;
    logic [fwh_pkg::ID_W-1:0]       who_reg;
    logic [fwh_pkg::COUNT_W-1:0]    count_reg;

    // Decide at accept, advance pointers and issue the RAM access
    fwh_ctrl #(
        .ITEM_DEPTH   (ITEM_DEPTH),
        .WAITER_DEPTH (WAITER_DEPTH),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .operation    (operation),
        .item_value   (item_value),
        .requester_id (requester_id),
        .busy         (busy),
        .item_we      (item_we),
        .item_waddr   (item_waddr),
        .item_wdata   (item_wdata),
        .item_re      (item_re),
        .item_raddr   (item_raddr),
        .waiter_we    (waiter_we),
        .waiter_waddr (waiter_waddr),
        .waiter_wdata (waiter_wdata),
        .waiter_re    (waiter_re),
        .waiter_raddr (waiter_raddr),
        .pend_valid   (pend_valid),
        .pend         (pend)
    );

    // Stored data words
    fwh_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (ITEM_DEPTH)
    ) u_item_ram (
        .clk   (clk),
        .we    (item_we),
        .waddr (item_waddr),
        .wdata (item_wdata),
        .re    (item_re),
        .raddr (item_raddr),
        .rdata (item_rdata)
    );

    // Parked consumer ids
    fwh_ram #(
        .WIDTH (fwh_pkg::ID_W),
        .DEPTH (WAITER_DEPTH)
    ) u_waiter_ram (
        .clk   (clk),
        .we    (waiter_we),
        .waddr (waiter_waddr),
        .wdata (waiter_wdata),
        .re    (waiter_re),
        .raddr (waiter_raddr),
        .rdata (waiter_rdata)
    );

    // Strobe for exactly one cycle after the pending cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pend_valid;
        end
    end

    // Merge RAM read data into the pending result; hold otherwise
    always_ff @(posedge clk)
    begin
        if (pend_valid)
        begin
            status_reg <= pend.status;
            value_reg  <= pend.use_item_ram ? fwh_pkg::VALUE_W'(item_rdata) : pend.value;
            who_reg    <= pend.use_waiter_ram ? waiter_rdata : pend.who;
            count_reg  <= pend.count;
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign delivered_value = value_reg;
    assign consumer_id     = who_reg;
    assign delivery_count  = count_reg;

    `FWH_ASSERT_NEXT(a_pend_gives_done, pend_valid, done_reg, "pending item gave no result")
    `FWH_ASSERT_NEXT(a_done_single, done_reg, !done_reg, "result strobe longer than one cycle")
    `FWH_ASSERT_NOW(a_done_not_busy, !(done_reg && busy), "result shown while busy")
endmodule
`default_nettype wire

/* sim/fifo_with_waiter_handoff_top_tb.sv */
// Self-checking testbench for fifo_with_waiter_handoff_top: directed and random
// enqueue/dequeue traffic, every result checked against a cycle-free queue model.
// Depends on fwh_pkg and the fifo_with_waiter_handoff_top RTL.
`default_nettype none
module fifo_with_waiter_handoff_top_tb;
    import fwh_pkg::*;

    localparam int ITEM_DEPTH   = ITEM_DEPTH_DEF;
    localparam int WAITER_DEPTH = WAITER_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1030;
    // Slowest legal spacing is the largest random gap plus the issue interval;
    // this leaves a wide margin before declaring the block hung.
    localparam int STALL_LIMIT  = 500;
    // Result of an item shows once its pending result reaches the result register; wait a bit longer.
    localparam int DRAIN_CYCLES = 4;

    // One predicted result item
    typedef struct {
        status_t              status;
        logic [VALUE_W-1:0]   value;
        logic [ID_W-1:0]      who;
        logic [COUNT_W-1:0]   count;
    } handoff_t;

    // Tracks the word FIFO, the waiter FIFO and the delivery counter, and
    // holds the results still owed by the block in issue order.
    class handoff_tracker;
        logic [VALUE_W-1:0] word_mem [ITEM_DEPTH];
        logic [ID_W-1:0]    waiter_mem [WAITER_DEPTH];
        int                 word_rd, word_wr, word_level;
        int                 waiter_rd, waiter_wr, waiter_level;
        logic [COUNT_W-1:0] handoffs;
        handoff_t           owed_q [$];
        int                 errors;

        function new();
            word_rd      = 0;
            word_wr      = 0;
            word_level   = 0;
            waiter_rd    = 0;
            waiter_wr    = 0;
            waiter_level = 0;
            handoffs     = '0;
            errors       = 0;
        endfunction

        // Apply one accepted item to the model and queue its result
        function void take_request(logic op, logic [VALUE_W-1:0] word, logic [ID_W-1:0] id);
            handoff_t outcome;
            outcome.value = '0;
            outcome.who   = '0;
            if (op == OP_ENQUEUE)
            begin
                if (waiter_level > 0)
                begin
                    // Hand the word straight to the oldest parked consumer
                    outcome.who    = waiter_mem[waiter_rd];
                    waiter_rd      = (waiter_rd + 1) % WAITER_DEPTH;
                    waiter_level   = waiter_level - 1;
                    outcome.value  = word;
                    handoffs       = handoffs + 1'b1;
                    outcome.status = ST_DELIVERED;
                end
                else if (word_level < ITEM_DEPTH)
                begin
                    word_mem[word_wr] = word;
                    word_wr           = (word_wr + 1) % ITEM_DEPTH;
                    word_level        = word_level + 1;
                    outcome.status    = ST_STORED;
                end
                else
                begin
                    outcome.status = ST_DROPPED;
                end
            end
            else
            begin
                if (word_level > 0 && waiter_level == 0)
                begin
                    outcome.value  = word_mem[word_rd];
                    word_rd        = (word_rd + 1) % ITEM_DEPTH;
                    word_level     = word_level - 1;
                    outcome.who    = id;
                    handoffs       = handoffs + 1'b1;
                    outcome.status = ST_DELIVERED;
                end
                else if (waiter_level < WAITER_DEPTH)
                begin
                    waiter_mem[waiter_wr] = id;
                    waiter_wr             = (waiter_wr + 1) % WAITER_DEPTH;
                    waiter_level          = waiter_level + 1;
                    outcome.status        = ST_PARKED;
                end
                else
                begin
                    outcome.status = ST_REJECTED;
                end
            end
            outcome.count = handoffs;
            owed_q.push_back(outcome);
        endfunction

        // Compare one result item against the oldest one owed
        function void match_result(logic [2:0] st, logic [VALUE_W-1:0] value,
                                   logic [ID_W-1:0] who, logic [COUNT_W-1:0] count);
            handoff_t oldest;
            if (owed_q.size() == 0)
            begin
                $error("result with nothing outstanding: status %0d", st);
                errors++;
                return;
            end
            oldest = owed_q.pop_front();
            if (st !== oldest.status)
            begin
                $error("status: expected %0d, got %0d", oldest.status, st);
                errors++;
            end
            if (value !== oldest.value)
            begin
                $error("delivered_value: expected %h, got %h", oldest.value, value);
                errors++;
            end
            if (who !== oldest.who)
            begin
                $error("consumer_id: expected %0d, got %0d", oldest.who, who);
                errors++;
            end
            if (count !== oldest.count)
            begin
                $error("delivery_count: expected %0d, got %0d", oldest.count, count);
                errors++;
            end
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction
    endclass

    // Block inputs start at known values before the first edge
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic               operation    = OP_ENQUEUE;
    logic [VALUE_W-1:0] item_value   = '0;
    logic [ID_W-1:0]    requester_id = '0;

    logic               busy;
    logic               done;
    logic [2:0]         status;
    logic [VALUE_W-1:0] delivered_value;
    logic [ID_W-1:0]    consumer_id;
    logic [COUNT_W-1:0] delivery_count;

    handoff_tracker     tracker;
    bit                 allow_gaps = 1'b1;
    int                 stall_cycles = 0;

    fifo_with_waiter_handoff_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .item_value      (item_value),
        .requester_id    (requester_id),
        .done            (done),
        .status          (status),
        .delivered_value (delivered_value),
        .consumer_id     (consumer_id),
        .delivery_count  (delivery_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample both sides at the edge: check a finishing result first, then
    // record the item taken at this same edge. All values read here are the
    // ones held before the edge, since every driver uses nonblocking updates.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.match_result(status, delivered_value, consumer_id, delivery_count);
            if (start && !busy)
                tracker.take_request(operation, item_value, requester_id);
        end
    end

    // Watchdog: count cycles in which neither an item nor a result moves
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[fifo_with_waiter_handoff_top] ERROR");
            $finish;
        end
    end

    // Drive one item: idle a random number of cycles, then hold start and the
    // fields until an edge sees busy low. With no gap, start stays high and
    // only the fields change, so back-to-back issue is exercised.
    task automatic issue_item(input op_t op, input logic [VALUE_W-1:0] word,
                              input logic [ID_W-1:0] id);
        int gap;
        gap = allow_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        operation    <= op;
        item_value   <= word;
        requester_id <= id;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        int                 n;
        int                 k;
        int                 burst;
        int                 mode;
        int                 pick;
        op_t                op;
        logic [VALUE_W-1:0] word;

        tracker = new();

        // Hold reset low, then release it on an edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: park and serve with extreme ids and words
        issue_item(OP_DEQUEUE, 32'h1234_5678, 8'h00);    // nothing stored: park id 0
        issue_item(OP_ENQUEUE, 32'h0000_0000, 8'hFF);    // serve the parked consumer
        issue_item(OP_ENQUEUE, 32'hFFFF_FFFF, 8'h00);    // no waiter: store
        issue_item(OP_DEQUEUE, 32'h0000_0000, 8'hFF);    // take the stored word
        // Fill the waiter store, then one more is rejected
        for (k = 0; k < WAITER_DEPTH; k++)
            issue_item(OP_DEQUEUE, $urandom, (k == 0) ? 8'hA5 : 8'(8'h5A + k));
        issue_item(OP_DEQUEUE, 32'hDEAD_BEEF, 8'h77);
        // Drain the waiters with enqueues of alternating bit patterns
        for (k = 0; k < WAITER_DEPTH; k++)
            issue_item(OP_ENQUEUE, (k % 2 == 0) ? 32'hAAAA_AAAA : 32'h5555_5555, 8'h00);

        // Random: bursts leaning toward enqueue fill the word store until
        // words drop, bursts leaning toward dequeue fill the waiter store until
        // requesters are rejected, other bursts mix both evenly; some bursts run with no idle cycles.
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            mode       = $urandom_range(0, 2);
            burst      = $urandom_range(10, 60);
            allow_gaps = ($urandom_range(0, 3) != 0);
            for (k = 0; k < burst && n < RANDOM_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                case (mode)
                    0:       op = (pick < 85) ? OP_ENQUEUE : OP_DEQUEUE;
                    1:       op = (pick < 15) ? OP_ENQUEUE : OP_DEQUEUE;
                    default: op = (pick < 50) ? OP_ENQUEUE : OP_DEQUEUE;
                endcase
                case ($urandom_range(0, 7))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = $urandom;
                endcase
                issue_item(op, word, 8'($urandom_range(0, 255)));
                n++;
            end
        end
        start <= 1'b0;

        // Wait for every owed result, then a few more cycles for strays
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("[fifo_with_waiter_handoff_top] OK");
        else
            $display("[fifo_with_waiter_handoff_top] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

/* fifo_with_waiter_handoff_top.f */
+incdir+hdl
hdl/fwh_pkg.sv
hdl/fwh_ram.sv
hdl/fwh_ctrl.sv
hdl/fifo_with_waiter_handoff_top.sv
sim/fifo_with_waiter_handoff_top_tb.sv
